// ===== src/apq_pkg.sv =====
// Types and constants shared by the aging priority queue and its ranking unit.
// No dependencies.
`default_nettype none

package apq_pkg;

   localparam int TIME_W     = 32;
   localparam int ORDER_W    = 32;
   localparam int ID_W       = 16;
   localparam int SECTOR_W   = 3;
   localparam int PRIO_W     = 2;
   localparam int PTIME_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 6;
   localparam int THRESH_W   = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [THRESH_W-1:0] AGE_ONE_RESET = 16'd4;
   localparam logic [THRESH_W-1:0] AGE_TWO_RESET = 16'd8;

   localparam logic [CSR_INDEX_W-1:0] CSR_AGE_ONE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AGE_TWO = 4'd1;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

   typedef struct packed {
      logic                func;
      logic [TIME_W-1:0]   now;
      logic [ID_W-1:0]     request_id;
      logic [SECTOR_W-1:0] sector;
      logic [PRIO_W-1:0]   base_priority;
      logic [PTIME_W-1:0]  print_time;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_request_id;
      logic [SECTOR_W-1:0] out_sector;
      logic [PTIME_W-1:0]  out_print_time;
      logic [PRIO_W-1:0]   effective_priority;
      logic [OCC_W-1:0]    occupancy;
   } rsp_item_type;

   // one stored request
   typedef struct packed {
      logic [TIME_W-1:0]   created;
      logic [PRIO_W-1:0]   base_priority;
      logic [ID_W-1:0]     request_id;
      logic [SECTOR_W-1:0] sector;
      logic [PTIME_W-1:0]  print_time;
      logic [ORDER_W-1:0]  insert_order;
   } entry_type;

   // payload of a ranked candidate
   typedef struct packed {
      logic [ID_W-1:0]     request_id;
      logic [SECTOR_W-1:0] sector;
      logic [PTIME_W-1:0]  print_time;
      logic [PRIO_W-1:0]   eff_prio;
   } rank_best_type;

   typedef struct packed {
      logic clear;
      logic sample;
   } rank_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_REM_SCAN,
      ST_REM_DRAIN,
      ST_REM_TAKE
   } state_type;

endpackage

`default_nettype wire

// ===== src/apq_rank.sv =====
// Ranking unit: ages one stored entry per cycle and keeps the best one seen.
// Depends on apq_pkg.
`default_nettype none

module apq_rank #(
   parameter int IDX_W = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  apq_pkg::rank_ctl_type             ctl,
   input  logic [IDX_W-1:0]                  sample_idx,
   input  apq_pkg::entry_type                sample_entry,
   input  logic [apq_pkg::TIME_W-1:0]        now,
   input  logic [apq_pkg::ORDER_W-1:0]       insert_counter,
   input  logic [apq_pkg::THRESH_W-1:0]      age_one,
   input  logic [apq_pkg::THRESH_W-1:0]      age_two,
   output logic [IDX_W-1:0]                  best_idx,
   output apq_pkg::rank_best_type            best
);
   import apq_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [TIME_W-1:0]   s1_created_ff;
   logic [ORDER_W-1:0]  s1_age_ff;
   rank_best_type       s1_cand_ff, s1_cand_in;

   logic                found_ff, found_in;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [TIME_W-1:0]   best_created_ff;
   logic [ORDER_W-1:0]  best_age_ff;
   rank_best_type       best_ff;

   logic [TIME_W-1:0]   wait_t;
   logic [PRIO_W-1:0]   aged;
   logic                take;

   // stage 1: aged priority and insert age
   always_comb begin
      if (now >= sample_entry.created) begin
         wait_t = now - sample_entry.created;
      end else begin
         wait_t = '0;
      end
      if (wait_t >= {{(TIME_W-THRESH_W){1'b0}}, age_two}) begin
         aged = (sample_entry.base_priority >= PRIO_W'(2)) ?
                sample_entry.base_priority - PRIO_W'(2) : '0;
      end else if (wait_t >= {{(TIME_W-THRESH_W){1'b0}}, age_one}) begin
         aged = (sample_entry.base_priority >= PRIO_W'(1)) ?
                sample_entry.base_priority - PRIO_W'(1) : '0;
      end else begin
         aged = sample_entry.base_priority;
      end
      s1_cand_in.request_id = sample_entry.request_id;
      s1_cand_in.sector     = sample_entry.sector;
      s1_cand_in.print_time = sample_entry.print_time;
      s1_cand_in.eff_prio   = aged;
      s1_valid_in = ctl.sample && !ctl.clear;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_idx_ff     <= sample_idx;
      s1_created_ff <= sample_entry.created;
      s1_age_ff     <= insert_counter - sample_entry.insert_order;
      s1_cand_ff    <= s1_cand_in;
   end

   // stage 2: lower priority, then older stamp, then earlier insert
   always_comb begin
      if (!found_ff) begin
         take = 1'b1;
      end else if (s1_cand_ff.eff_prio != best_ff.eff_prio) begin
         take = s1_cand_ff.eff_prio < best_ff.eff_prio;
      end else if (s1_created_ff != best_created_ff) begin
         take = s1_created_ff < best_created_ff;
      end else begin
         take = s1_age_ff > best_age_ff;
      end
      if (ctl.clear) begin
         found_in = 1'b0;
      end else begin
         found_in = found_ff || s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      if (s1_valid_ff && !ctl.clear && take) begin
         best_idx_ff     <= s1_idx_ff;
         best_created_ff <= s1_created_ff;
         best_age_ff     <= s1_age_ff;
         best_ff         <= s1_cand_ff;
      end
   end

   assign best_idx = best_idx_ff;
   assign best     = best_ff;

endmodule

`default_nettype wire

// ===== src/aging_priority_queue.sv =====
// Top level of the aging priority queue: sequencer, entry memory, valid bits.
// Depends on apq_pkg and apq_rank.
//
//  channel | ports                                 | transfer when
//  --------+---------------------------------------+--------------------------
//  request | start, busy, req_data                 | start && !busy
//  result  | rsp_valid, rsp_data                   | rsp_valid (one cycle)
//  config  | csr_valid, csr_ready, csr_index/wdata | csr_valid && csr_ready
//
// Insert: scans the slots one per cycle for the lowest free one and registers
// the result when it finds it. Full store or empty remove: result in the next
// cycle. Remove: the single-port entry memory and the ranking unit walk every
// slot. Reset is synchronous; it clears the valid bits and counters, no memory
// sweep is needed. Results cannot be stalled; csr_ready is always high.
`default_nettype none

module aging_priority_queue #(
   parameter int CAPACITY = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  apq_pkg::req_item_type              req_data,
   output logic                               rsp_valid,
   output apq_pkg::rsp_item_type              rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [apq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [apq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import apq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   state_type             state_ff, state_in;
   req_item_type          req_ff, req_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  drain_ff, drain_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ORDER_W-1:0]    counter_ff, counter_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_ff, rsp_in;
   logic [THRESH_W-1:0]   age_one_ff, age_two_ff;

   logic                  s0_valid_ff, s0_valid_in;
   logic [IDX_W-1:0]      s0_idx_ff;

   entry_type             mem [CAPACITY];
   entry_type             rd_data_ff;
   entry_type             wr_data;
   logic                  mem_we;

   rank_ctl_type          rank_ctl;
   logic [IDX_W-1:0]      best_idx;
   rank_best_type         best;

   logic                  accept;
   logic                  slot_free;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign slot_free = !valid_ff[scan_idx_ff];
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         age_one_ff <= AGE_ONE_RESET;
         age_two_ff <= AGE_TWO_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AGE_ONE: age_one_ff <= csr_wdata;
            CSR_AGE_TWO: age_two_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.func == FUNC_INSERT) begin
                  if (count_ff != FULL_CNT) state_in = ST_INS_SCAN;
               end else begin
                  if (count_ff != '0) state_in = ST_REM_SCAN;
               end
            end
         end
         ST_INS_SCAN: begin
            if (slot_free) state_in = ST_IDLE;
         end
         ST_REM_SCAN: begin
            if (scan_idx_ff == LAST_IDX) state_in = ST_REM_DRAIN;
         end
         ST_REM_DRAIN: begin
            if (drain_ff) state_in = ST_REM_TAKE;
         end
         ST_REM_TAKE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      req_in       = req_ff;
      scan_idx_in  = scan_idx_ff;
      drain_in     = drain_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      counter_in   = counter_ff;
      mem_we       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      wr_data.created       = req_ff.now;
      wr_data.base_priority = req_ff.base_priority;
      wr_data.request_id    = req_ff.request_id;
      wr_data.sector        = req_ff.sector;
      wr_data.print_time    = req_ff.print_time;
      wr_data.insert_order  = counter_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               scan_idx_in = '0;
               drain_in    = 1'b0;
               if (req_data.func == FUNC_INSERT && count_ff == FULL_CNT) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in           = '0;
                  rsp_in.status    = STATUS_FULL;
                  rsp_in.occupancy = OCC_W'(count_ff);
               end else if (req_data.func == FUNC_REMOVE && count_ff == '0) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in           = '0;
                  rsp_in.status    = STATUS_EMPTY;
                  rsp_in.occupancy = OCC_W'(count_ff);
               end
            end
         end
         ST_INS_SCAN: begin
            if (slot_free) begin
               mem_we                = 1'b1;
               valid_in[scan_idx_ff] = 1'b1;
               count_in              = count_ff + CNT_W'(1);
               counter_in            = counter_ff + ORDER_W'(1);
               rsp_valid_in          = 1'b1;
               rsp_in                = '0;
               rsp_in.status         = STATUS_INSERTED;
               rsp_in.occupancy      = OCC_W'(count_in);
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_REM_SCAN: begin
            if (scan_idx_ff != LAST_IDX) scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
         ST_REM_DRAIN: begin
            drain_in = 1'b1;
         end
         ST_REM_TAKE: begin
            valid_in[best_idx]        = 1'b0;
            count_in                  = count_ff - CNT_W'(1);
            rsp_valid_in              = 1'b1;
            rsp_in.status             = STATUS_REMOVED;
            rsp_in.out_request_id     = best.request_id;
            rsp_in.out_sector         = best.sector;
            rsp_in.out_print_time     = best.print_time;
            rsp_in.effective_priority = best.eff_prio;
            rsp_in.occupancy          = OCC_W'(count_in);
         end
         default: ;
      endcase
   end

   assign s0_valid_in = (state_ff == ST_REM_SCAN) && valid_ff[scan_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         s0_valid_ff  <= 1'b0;
         drain_ff     <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
         s0_valid_ff  <= s0_valid_in;
         drain_ff     <= drain_in;
         scan_idx_ff  <= scan_idx_in;
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      s0_idx_ff <= scan_idx_ff;
   end

   // entry memory: a registered read every cycle and, when enabled, a write, both at the scan index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[scan_idx_ff] <= wr_data;
      end
      rd_data_ff <= mem[scan_idx_ff];
   end

   assign rank_ctl = '{clear: (state_ff == ST_IDLE), sample: s0_valid_ff};

   apq_rank #(
      .IDX_W(IDX_W)
   ) u_rank (
      .clock          (clock),
      .reset          (reset),
      .ctl            (rank_ctl),
      .sample_idx     (s0_idx_ff),
      .sample_entry   (rd_data_ff),
      .now            (req_ff.now),
      .insert_counter (counter_ff),
      .age_one        (age_one_ff),
      .age_two        (age_two_ff),
      .best_idx       (best_idx),
      .best           (best)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== tb/aging_priority_queue_tb.sv =====
// Self-checking testbench for aging_priority_queue: directed and random inserts and
// removes, checked result by result against an in-bench model of the aged select.
// Depends on apq_pkg and the aging_priority_queue RTL.
`timescale 1ns / 1ps

module aging_priority_queue_tb;

   import apq_pkg::*;

   localparam int CAPACITY     = 32;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int REPORT_MAX   = 10;

   // no register lives here; a write must leave the thresholds alone
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_TOP = '1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   busy;
   req_item_type           req_data  = '0;
   logic                   rsp_valid;
   rsp_item_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // queue model
   logic                slot_used [CAPACITY];
   entry_type           slot_entry [CAPACITY];
   logic [ORDER_W-1:0]  insert_seq;
   int                  stored;
   logic [THRESH_W-1:0] thresh_one;
   logic [THRESH_W-1:0] thresh_two;

   rsp_item_type pending_results [$];
   int           mismatch_count = 0;
   int           idle_pct = 0;
   int           cycle_count;

   aging_priority_queue #(.CAPACITY(CAPACITY)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Applies one request to the model and returns the result the block owes.
   function automatic rsp_item_type queue_step_result(req_item_type item);
      rsp_item_type       res;
      int                 free_slot;
      int                 best;
      logic               found;
      logic               take;
      logic [TIME_W-1:0]  wait_len;
      logic [TIME_W-1:0]  best_created;
      logic [ORDER_W-1:0] age;
      logic [ORDER_W-1:0] best_age;
      logic [PRIO_W-1:0]  prio;
      logic [PRIO_W-1:0]  best_prio;
      res = '0;
      if (item.func == FUNC_INSERT) begin
         free_slot = -1;
         for (int i = CAPACITY - 1; i >= 0; i--)
            if (!slot_used[i]) free_slot = i;
         if (free_slot < 0) begin
            res.status = STATUS_FULL;
         end else begin
            slot_used[free_slot] = 1'b1;
            slot_entry[free_slot] = '{created: item.now, base_priority: item.base_priority,
                                      request_id: item.request_id, sector: item.sector,
                                      print_time: item.print_time, insert_order: insert_seq};
            insert_seq = insert_seq + 1'b1;
            stored++;
            res.status = STATUS_INSERTED;
         end
      end else begin
         found = 1'b0;
         best = 0;
         best_prio = '0;
         best_created = '0;
         best_age = '0;
         for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i]) begin
               // a stamp in the future counts as no wait at all
               wait_len = (item.now >= slot_entry[i].created) ?
                          item.now - slot_entry[i].created : '0;
               prio = slot_entry[i].base_priority;
               if (wait_len >= TIME_W'(thresh_two))
                  prio = (prio >= 2'd2) ? prio - 2'd2 : 2'd0;
               else if (wait_len >= TIME_W'(thresh_one))
                  prio = (prio >= 2'd1) ? prio - 2'd1 : 2'd0;
               age = insert_seq - slot_entry[i].insert_order;
               if (!found)
                  take = 1'b1;
               else if (prio != best_prio)
                  take = prio < best_prio;
               else if (slot_entry[i].created != best_created)
                  take = slot_entry[i].created < best_created;
               else
                  take = age > best_age;
               if (take) begin
                  found = 1'b1;
                  best = i;
                  best_prio = prio;
                  best_created = slot_entry[i].created;
                  best_age = age;
               end
            end
         end
         if (!found) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.status = STATUS_REMOVED;
            res.out_request_id = slot_entry[best].request_id;
            res.out_sector = slot_entry[best].sector;
            res.out_print_time = slot_entry[best].print_time;
            res.effective_priority = best_prio;
            slot_used[best] = 1'b0;
            stored--;
         end
      end
      res.occupancy = OCC_W'(stored);
      return res;
   endfunction

   function automatic req_item_type random_item(logic fn, logic [TIME_W-1:0] stamp_val);
      req_item_type item;
      item.func = fn;
      item.now = stamp_val;
      item.request_id = ID_W'($urandom);
      item.sector = SECTOR_W'($urandom);
      item.base_priority = PRIO_W'($urandom);
      item.print_time = PTIME_W'($urandom);
      return item;
   endfunction

   task automatic report_mismatch(string what, rsp_item_type exp_r, rsp_item_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0t %s: expected st=%0d id=%h sec=%0d pt=%h eff=%0d occ=%0d, got st=%0d id=%h sec=%0d pt=%h eff=%0d occ=%0d",
                  $realtime, what, exp_r.status, exp_r.out_request_id, exp_r.out_sector,
                  exp_r.out_print_time, exp_r.effective_priority, exp_r.occupancy,
                  got.status, got.out_request_id, got.out_sector, got.out_print_time,
                  got.effective_priority, got.occupancy);
   endtask

   // Called right after a rising edge; returns at the edge of the transfer.
   task automatic send_request(req_item_type item);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(7, 45) : $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      pending_results.push_back(queue_step_result(item));
   endtask

   task automatic send_fields(logic fn, logic [TIME_W-1:0] stamp_val, logic [ID_W-1:0] id,
                              logic [SECTOR_W-1:0] sec, logic [PRIO_W-1:0] prio,
                              logic [PTIME_W-1:0] pt);
      send_request('{func: fn, now: stamp_val, request_id: id, sector: sec,
                     base_priority: prio, print_time: pt});
   endtask

   // Sender holds off until every owed result has come and the block is idle.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0 || busy);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_AGE_ONE)
         thresh_one = data;
      else if (index == CSR_AGE_TWO)
         thresh_two = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_empty_remove();
      send_fields(FUNC_REMOVE, 32'h0, 16'hFFFF, 3'd7, 2'd3, 8'hFF);
   endtask

   task automatic test_field_extremes();
      send_fields(FUNC_INSERT, 32'h0, 16'h0000, 3'd0, 2'd0, 8'h00);
      send_fields(FUNC_INSERT, 32'h0, 16'hFFFF, 3'd7, 2'd3, 8'hFF);
      send_fields(FUNC_REMOVE, 32'hFFFF_FFFF, 16'h0, 3'd0, 2'd0, 8'h0);
      send_fields(FUNC_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 2'd3, 8'hFF);
      send_fields(FUNC_INSERT, 32'hFFFF_FFFF, 16'hA5C3, 3'd5, 2'd2, 8'h5A);
      send_fields(FUNC_REMOVE, 32'hFFFF_FFFF, 16'h0, 3'd0, 2'd0, 8'h0);
      send_fields(FUNC_REMOVE, 32'hFFFF_FFFF, 16'h0, 3'd0, 2'd0, 8'h0);
   endtask

   task automatic test_time_backwards();
      send_fields(FUNC_INSERT, 32'd1000, 16'h0101, 3'd1, 2'd2, 8'h11);
      send_fields(FUNC_INSERT, 32'd1005, 16'h0202, 3'd2, 2'd1, 8'h22);
      send_fields(FUNC_REMOVE, 32'd500, 16'h0, 3'd0, 2'd0, 8'h0);
      send_fields(FUNC_REMOVE, 32'd1020, 16'h0, 3'd0, 2'd0, 8'h0);
   endtask

   task automatic test_tie_order();
      send_fields(FUNC_INSERT, 32'd50, 16'h1111, 3'd3, 2'd1, 8'h01);
      send_fields(FUNC_INSERT, 32'd50, 16'h2222, 3'd4, 2'd1, 8'h02);
      send_fields(FUNC_INSERT, 32'd60, 16'h3333, 3'd6, 2'd2, 8'h03);
      send_fields(FUNC_INSERT, 32'd70, 16'h4444, 3'd0, 2'd0, 8'h04);
      send_fields(FUNC_REMOVE, 32'd50, 16'h0, 3'd0, 2'd0, 8'h0);
      send_fields(FUNC_REMOVE, 32'd66, 16'h0, 3'd0, 2'd0, 8'h0);
      send_fields(FUNC_REMOVE, 32'd80, 16'h0, 3'd0, 2'd0, 8'h0);
      send_fields(FUNC_REMOVE, 32'd80, 16'h0, 3'd0, 2'd0, 8'h0);
   endtask

   task automatic test_threshold_order();
      drain_results();
      write_csr(CSR_AGE_ONE, 16'd10);
      write_csr(CSR_AGE_TWO, 16'd3);
      write_csr(CSR_UNUSED_TOP, 16'hFFFF);
      send_fields(FUNC_INSERT, 32'd100, 16'h5555, 3'd2, 2'd3, 8'h80);
      send_fields(FUNC_REMOVE, 32'd105, 16'h0, 3'd0, 2'd0, 8'h0);
      drain_results();
      write_csr(CSR_AGE_ONE, 16'd0);
      write_csr(CSR_AGE_TWO, 16'd0);
      send_fields(FUNC_INSERT, 32'd200, 16'h6666, 3'd7, 2'd1, 8'h7F);
      send_fields(FUNC_REMOVE, 32'd200, 16'h0, 3'd0, 2'd0, 8'h0);
   endtask

   // fill past capacity, then empty it and one remove more
   task automatic test_full_store();
      logic [TIME_W-1:0] stamp;
      drain_results();
      write_csr(CSR_AGE_ONE, AGE_ONE_RESET);
      write_csr(CSR_AGE_TWO, AGE_TWO_RESET);
      stamp = $urandom;
      repeat (CAPACITY + 2) begin
         stamp = stamp + $urandom_range(0, 2);
         send_request(random_item(FUNC_INSERT, stamp));
      end
      repeat (CAPACITY + 1) begin
         stamp = stamp + $urandom_range(0, 2);
         send_request(random_item(FUNC_REMOVE, stamp));
      end
   endtask

   task automatic test_random_phase(int pct, logic [THRESH_W-1:0] th1,
                                    logic [THRESH_W-1:0] th2, int count);
      logic [TIME_W-1:0] stamp;
      int                sent;
      int                burst;
      int                ins_pct;
      int                pick;
      logic              fn;
      drain_results();
      write_csr(CSR_AGE_ONE, th1);
      write_csr(CSR_AGE_TWO, th2);
      idle_pct = pct;
      stamp = $urandom;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(10, 60);
         pick = $urandom_range(2);
         // biased bursts swing the store between empty and full
         ins_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 85;
         repeat (burst) begin
            pick = $urandom_range(99);
            if (pick < 4)
               stamp = stamp - $urandom_range(1, 20);
            else if (pick < 7)
               stamp = stamp + $urandom_range(60000, 140000);
            else
               stamp = stamp + $urandom_range(0, 6);
            fn = ($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
            send_request(random_item(fn, stamp));
            sent++;
         end
         if ($urandom_range(7) == 0)
            drain_results();
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_item_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", '0, rsp_data);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_data.status !== exp_r.status
                || rsp_data.out_request_id !== exp_r.out_request_id
                || rsp_data.out_sector !== exp_r.out_sector
                || rsp_data.out_print_time !== exp_r.out_print_time
                || rsp_data.effective_priority !== exp_r.effective_priority
                || rsp_data.occupancy !== exp_r.occupancy)
               report_mismatch("result mismatch", exp_r, rsp_data);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL aging_priority_queue");
      $finish;
   end

   initial begin
      for (int i = 0; i < CAPACITY; i++) begin
         slot_used[i] = 1'b0;
         slot_entry[i] = '0;
      end
      insert_seq = '0;
      stored = 0;
      thresh_one = AGE_ONE_RESET;
      thresh_two = AGE_TWO_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_remove();
      test_field_extremes();
      test_time_backwards();
      test_tie_order();
      test_threshold_order();
      test_full_store();

      test_random_phase(0, AGE_ONE_RESET, AGE_TWO_RESET, 230);
      test_random_phase(59, 16'd0, 16'd0, 230);
      test_random_phase(0, 16'hFFFF, 16'hFFFF, 230);
      test_random_phase(34, 16'd12, 16'd3, 230);
      test_random_phase(59, THRESH_W'($urandom_range(0, 40)),
                        THRESH_W'($urandom_range(0, 80)), 230);
      test_random_phase(34, 16'd1, 16'hFFFF, 230);
      test_random_phase(0, THRESH_W'($urandom), THRESH_W'($urandom_range(0, 64)), 230);
      test_random_phase(34, 16'hFFFF, 16'd0, 230);

      drain_results();
      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("PASS aging_priority_queue");
      else
         $display("FAIL aging_priority_queue");
      $finish;
   end

endmodule
